### src/spi_pkg.sv
// Shared types, widths and register codes for the segment/plane intersection core.
`default_nettype none
package spi_pkg;

    localparam int COORD_WIDTH = 32;
    localparam int SAT_BITS    = (COORD_WIDTH > 32) ? 32 : ((COORD_WIDTH < 2) ? 2 : COORD_WIDTH);

    localparam int CW   = 32;          // coordinate field width
    localparam int TOLW = 31;          // tolerance register width
    localparam int XW   = CW + 1;      // coordinate difference
    localparam int PW   = CW + XW;     // normal times difference
    localparam int SW   = PW + 2;      // signed distance
    localparam int BW   = SW + 1;      // den = s2 - s1
    localparam int CH   = 23;          // multiplier chunk
    localparam int NCH  = 3;
    localparam int PPW  = CH + XW;     // partial product
    localparam int AW   = SW + XW;     // |num| * |d|
    localparam int NW   = AW + 2;      // 2a + b
    localparam int DVW  = BW + 1;      // divisor 2b
    localparam int QB   = 34;          // quotient bits kept; larger always clamps
    localparam int VW   = QB + 2;      // p1 +/- q

    localparam int DIST_ST  = 4;
    localparam int SCALE_ST = 4;
    localparam int DIV_ST   = QB;
    localparam int NST      = DIST_ST + SCALE_ST + DIV_ST + 1;

    localparam int IDXW = 3;

    typedef enum logic [IDXW-1:0] {
        REG_PPX = 3'd0,
        REG_PPY = 3'd1,
        REG_PPZ = 3'd2,
        REG_PNX = 3'd3,
        REG_PNY = 3'd4,
        REG_PNZ = 3'd5,
        REG_TOL = 3'd6
    } t_reg_idx;

    typedef enum logic [1:0] {
        SIDE_CROSS = 2'd0,
        SIDE_POS   = 2'd1,
        SIDE_NEG   = 2'd2
    } t_side;

    typedef struct packed {
        t_side                 status;
        logic                  deg;
        logic [2:0]            neg;
        logic [2:0][CW-1:0]    p1;
    } t_info;

endpackage
`default_nettype wire

### src/spi_dist.sv
// Signed plane distances of both endpoints, classification, num/den magnitudes.
`default_nettype none
module spi_dist (
    input  wire logic                                  i_clk,
    input  wire logic [spi_pkg::DIST_ST-1:0]           i_en,
    input  wire logic [2:0][spi_pkg::CW-1:0]           i_first,
    input  wire logic [2:0][spi_pkg::CW-1:0]           i_second,
    input  wire logic [2:0][spi_pkg::CW-1:0]           i_pp,
    input  wire logic [2:0][spi_pkg::CW-1:0]           i_pn,
    input  wire logic [spi_pkg::TOLW-1:0]              i_tol,
    output spi_pkg::t_info                             o_info,
    output logic [spi_pkg::SW-1:0]                     o_mag_num,
    output logic [spi_pkg::BW-1:0]                     o_mag_den,
    output logic [2:0][spi_pkg::XW-1:0]                o_mag_d
);
    localparam int XW = spi_pkg::XW;
    localparam int CW = spi_pkg::CW;
    localparam int PW = spi_pkg::PW;
    localparam int SW = spi_pkg::SW;
    localparam int BW = spi_pkg::BW;

    logic [2:0][XW-1:0] r0_dp1, r0_dp2, r0_d, n0_dp1, n0_dp2, n0_d;
    logic [2:0][CW-1:0] r0_p1, r1_p1, r2_p1;
    logic [2:0][PW-1:0] r1_m1, r1_m2, n1_m1, n1_m2;
    logic [2:0][XW-1:0] r1_d, r2_d;
    logic [SW-1:0]      r2_s1, r2_s2, n2_s1, n2_s2;
    spi_pkg::t_info     r3_info, n3_info;
    logic [SW-1:0]      r3_mag_num, n3_mag_num;
    logic [BW-1:0]      r3_mag_den, n3_mag_den, n3_den;
    logic [2:0][XW-1:0] r3_mag_d, n3_mag_d;
    logic               n3_num_neg;
    logic [1:0]         n3_c1, n3_c2;

    function automatic logic [1:0] classify(input logic [SW-1:0] s,
                                            input logic [spi_pkg::TOLW-1:0] tol);
        logic [SW-1:0] mag;
        logic [SW-1:0] lim;
        mag = s[SW-1] ? (~s + SW'(1)) : s;
        lim = SW'({tol, 16'b0});
        if (mag < lim || s == '0) begin
            return spi_pkg::SIDE_CROSS;
        end
        return s[SW-1] ? spi_pkg::SIDE_NEG : spi_pkg::SIDE_POS;
    endfunction

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n0_dp1[i] = {i_first[i][CW-1], i_first[i]} - {i_pp[i][CW-1], i_pp[i]};
            n0_dp2[i] = {i_second[i][CW-1], i_second[i]} - {i_pp[i][CW-1], i_pp[i]};
            n0_d[i]   = {i_second[i][CW-1], i_second[i]} - {i_first[i][CW-1], i_first[i]};
            n1_m1[i]  = $signed(i_pn[i]) * $signed(r0_dp1[i]);
            n1_m2[i]  = $signed(i_pn[i]) * $signed(r0_dp2[i]);
        end
        n2_s1 = SW'($signed(r1_m1[0])) + SW'($signed(r1_m1[1])) + SW'($signed(r1_m1[2]));
        n2_s2 = SW'($signed(r1_m2[0])) + SW'($signed(r1_m2[1])) + SW'($signed(r1_m2[2]));

        n3_den     = {r2_s2[SW-1], r2_s2} - {r2_s1[SW-1], r2_s1};
        n3_num_neg = !r2_s1[SW-1] && (r2_s1 != '0);
        n3_mag_num = r2_s1[SW-1] ? (~r2_s1 + SW'(1)) : r2_s1;
        n3_mag_den = n3_den[BW-1] ? (~n3_den + BW'(1)) : n3_den;
        n3_c1      = classify(r2_s1, i_tol);
        n3_c2      = classify(r2_s2, i_tol);
        n3_info.p1  = r2_p1;
        n3_info.deg = (n3_den == '0);
        if (n3_c1 == spi_pkg::SIDE_POS && n3_c2 == spi_pkg::SIDE_POS) begin
            n3_info.status = spi_pkg::SIDE_POS;
        end else if (n3_c1 == spi_pkg::SIDE_NEG && n3_c2 == spi_pkg::SIDE_NEG) begin
            n3_info.status = spi_pkg::SIDE_NEG;
        end else begin
            n3_info.status = spi_pkg::SIDE_CROSS;
        end
        for (int i = 0; i < 3; i++) begin
            n3_mag_d[i]    = r2_d[i][XW-1] ? (~r2_d[i] + XW'(1)) : r2_d[i];
            n3_info.neg[i] = n3_num_neg ^ r2_d[i][XW-1] ^ n3_den[BW-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r0_dp1 <= n0_dp1;
            r0_dp2 <= n0_dp2;
            r0_d   <= n0_d;
            r0_p1  <= i_first;
        end
        if (i_en[1]) begin
            r1_m1 <= n1_m1;
            r1_m2 <= n1_m2;
            r1_d  <= r0_d;
            r1_p1 <= r0_p1;
        end
        if (i_en[2]) begin
            r2_s1 <= n2_s1;
            r2_s2 <= n2_s2;
            r2_d  <= r1_d;
            r2_p1 <= r1_p1;
        end
        if (i_en[3]) begin
            r3_info    <= n3_info;
            r3_mag_num <= n3_mag_num;
            r3_mag_den <= n3_mag_den;
            r3_mag_d   <= n3_mag_d;
        end
    end

    assign o_info    = r3_info;
    assign o_mag_num = r3_mag_num;
    assign o_mag_den = r3_mag_den;
    assign o_mag_d   = r3_mag_d;

endmodule
`default_nettype wire

### src/spi_scale.sv
// Offset numerators |num|*|d| in chunked products, rounding setup and overflow check.
`default_nettype none
module spi_scale (
    input  wire logic                                  i_clk,
    input  wire logic [spi_pkg::SCALE_ST-1:0]          i_en,
    input  wire spi_pkg::t_info                        i_info,
    input  wire logic [spi_pkg::SW-1:0]                i_mag_num,
    input  wire logic [spi_pkg::BW-1:0]                i_mag_den,
    input  wire logic [2:0][spi_pkg::XW-1:0]           i_mag_d,
    output spi_pkg::t_info                             o_info,
    output logic [spi_pkg::DVW-1:0]                    o_den,
    output logic [2:0][spi_pkg::DVW-1:0]               o_rem,
    output logic [2:0][spi_pkg::QB-1:0]                o_low,
    output logic [2:0]                                 o_ovf
);
    localparam int CH  = spi_pkg::CH;
    localparam int NCH = spi_pkg::NCH;
    localparam int PPW = spi_pkg::PPW;
    localparam int AW  = spi_pkg::AW;
    localparam int NW  = spi_pkg::NW;
    localparam int BW  = spi_pkg::BW;
    localparam int DVW = spi_pkg::DVW;
    localparam int QB  = spi_pkg::QB;

    logic [NCH*CH-1:0]                  n4_pad;
    logic [2:0][NCH-1:0][PPW-1:0]       r4_pp, n4_pp;
    logic [BW-1:0]                      r4_b, r5_b;
    logic [2:0][AW-1:0]                 r5_a, n5_a;
    logic [2:0][NW-1:0]                 r6_n, n6_n;
    logic [DVW-1:0]                     r6_d, r7_d;
    logic [2:0][DVW-1:0]                r7_rem, n7_rem;
    logic [2:0][QB-1:0]                 r7_low, n7_low;
    logic [2:0]                         r7_ovf, n7_ovf;
    spi_pkg::t_info                     r4_info, r5_info, r6_info, r7_info;

    always_comb begin
        n4_pad = (NCH*CH)'(i_mag_num);
        for (int l = 0; l < 3; l++) begin
            for (int j = 0; j < NCH; j++) begin
                n4_pp[l][j] = PPW'(n4_pad[j*CH +: CH]) * PPW'(i_mag_d[l]);
            end
            n5_a[l] = AW'(r4_pp[l][0]) + (AW'(r4_pp[l][1]) << CH)
                    + (AW'(r4_pp[l][2]) << (2*CH));
            // round half away: (2a + b) / 2b
            n6_n[l] = {r5_a[l], 1'b0} + NW'(r5_b);
            n7_ovf[l] = ({1'b0, r6_n[l]} >= {r6_d, {QB{1'b0}}});
            n7_rem[l] = DVW'(r6_n[l][NW-1:QB]);
            n7_low[l] = r6_n[l][QB-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r4_pp   <= n4_pp;
            r4_b    <= i_mag_den;
            r4_info <= i_info;
        end
        if (i_en[1]) begin
            r5_a    <= n5_a;
            r5_b    <= r4_b;
            r5_info <= r4_info;
        end
        if (i_en[2]) begin
            r6_n    <= n6_n;
            r6_d    <= {r5_b, 1'b0};
            r6_info <= r5_info;
        end
        if (i_en[3]) begin
            r7_rem  <= n7_rem;
            r7_low  <= n7_low;
            r7_ovf  <= n7_ovf;
            r7_d    <= r6_d;
            r7_info <= r6_info;
        end
    end

    assign o_info = r7_info;
    assign o_den  = r7_d;
    assign o_rem  = r7_rem;
    assign o_low  = r7_low;
    assign o_ovf  = r7_ovf;

endmodule
`default_nettype wire

### src/spi_div.sv
// Pipelined restoring divider, one quotient bit per stage, three coordinate lanes.
`default_nettype none
module spi_div (
    input  wire logic                                  i_clk,
    input  wire logic [spi_pkg::DIV_ST-1:0]            i_en,
    input  wire spi_pkg::t_info                        i_info,
    input  wire logic [spi_pkg::DVW-1:0]               i_den,
    input  wire logic [2:0][spi_pkg::DVW-1:0]          i_rem,
    input  wire logic [2:0][spi_pkg::QB-1:0]           i_low,
    input  wire logic [2:0]                            i_ovf,
    output spi_pkg::t_info                             o_info,
    output logic [2:0][spi_pkg::QB-1:0]                o_q,
    output logic [2:0]                                 o_ovf
);
    localparam int DVW = spi_pkg::DVW;
    localparam int QB  = spi_pkg::QB;
    localparam int NS  = spi_pkg::DIV_ST;

    logic [2:0][DVW-1:0] r_rem [NS];
    logic [2:0][DVW-1:0] n_rem [NS];
    logic [2:0][DVW-1:0] p_rem [NS];
    logic [2:0][QB-1:0]  r_num [NS];
    logic [2:0][QB-1:0]  n_num [NS];
    logic [2:0][QB-1:0]  p_num [NS];
    logic [2:0][QB-1:0]  r_q   [NS];
    logic [2:0][QB-1:0]  n_q   [NS];
    logic [2:0][QB-1:0]  p_q   [NS];
    logic [DVW-1:0]      p_den [NS];
    logic [2:0]          r_ovf [NS];
    logic [DVW-1:0]      r_den [NS];
    spi_pkg::t_info      r_info [NS];

    always_comb begin
        logic [DVW:0] trial;
        p_rem[0] = i_rem;
        p_num[0] = i_low;
        p_q[0]   = '0;
        p_den[0] = i_den;
        for (int k = 1; k < NS; k++) begin
            p_rem[k] = r_rem[k-1];
            p_num[k] = r_num[k-1];
            p_q[k]   = r_q[k-1];
            p_den[k] = r_den[k-1];
        end
        for (int k = 0; k < NS; k++) begin
            for (int l = 0; l < 3; l++) begin
                trial = {p_rem[k][l], p_num[k][l][QB-1]};
                if (trial >= {1'b0, p_den[k]}) begin
                    n_rem[k][l] = DVW'(trial - {1'b0, p_den[k]});
                    n_q[k][l]   = {p_q[k][l][QB-2:0], 1'b1};
                end else begin
                    n_rem[k][l] = DVW'(trial);
                    n_q[k][l]   = {p_q[k][l][QB-2:0], 1'b0};
                end
                n_num[k][l] = {p_num[k][l][QB-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < NS; k++) begin
            if (i_en[k]) begin
                r_rem[k] <= n_rem[k];
                r_num[k] <= n_num[k];
                r_q[k]   <= n_q[k];
            end
        end
        if (i_en[0]) begin
            r_ovf[0]  <= i_ovf;
            r_den[0]  <= i_den;
            r_info[0] <= i_info;
        end
        for (int k = 1; k < NS; k++) begin
            if (i_en[k]) begin
                r_ovf[k]  <= r_ovf[k-1];
                r_den[k]  <= r_den[k-1];
                r_info[k] <= r_info[k-1];
            end
        end
    end

    assign o_info = r_info[NS-1];
    assign o_q    = r_q[NS-1];
    assign o_ovf  = r_ovf[NS-1];

endmodule
`default_nettype wire

### src/segment_plane_intersection_core.sv
// Top level: config registers, pipeline flow control, final clamp and output register.
//
// Segment against plane intersection in signed Q16.16.
// Input stream: one item per segment, tdata holds first_x/y/z then second_x/y/z.
// Output stream: one item per segment; tdata holds cross_x/y/z, tuser holds
// side_status, degenerate and saturated.
// Configuration: i_cfg_we writes i_cfg_data into register i_cfg_idx (plane point
// x/y/z, plane normal x/y/z, tolerance); the user must write while the pipeline is empty (not enforced).
// From input accept to output valid an item passes 43 register stages: four
// distance stages, four product/rounding stages, a 34-stage divider with one
// quotient bit per stage and the output register. Throughput is one item per
// cycle unless a stalled receiver fills every stage; the divider pipeline sets the depth.
// Reset restores the register defaults (normal along +z) and empties the pipeline.
// When the receiver stalls, the output holds and items pack into empty stages
// behind it, so the input keeps taking items until every stage is full.
`default_nettype none
module segment_plane_intersection_core (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_s_axis_tvalid,
    output logic                               o_s_axis_tready,
    // first_x, first_y, first_z, second_x, second_y, second_z
    input  wire logic [6*spi_pkg::CW-1:0]      i_s_axis_tdata,
    output logic                               o_m_axis_tvalid,
    input  wire logic                          i_m_axis_tready,
    // cross_x, cross_y, cross_z
    output logic [3*spi_pkg::CW-1:0]           o_m_axis_tdata,
    // side_status[1:0], degenerate, saturated
    output logic [3:0]                         o_m_axis_tuser,
    input  wire logic                          i_cfg_we,
    input  wire logic [spi_pkg::IDXW-1:0]      i_cfg_idx,
    input  wire logic [spi_pkg::CW-1:0]        i_cfg_data
);
    localparam int CW  = spi_pkg::CW;
    localparam int QB  = spi_pkg::QB;
    localparam int VW  = spi_pkg::VW;
    localparam int NST = spi_pkg::NST;
    localparam int D0  = 0;
    localparam int S0  = spi_pkg::DIST_ST;
    localparam int V0  = S0 + spi_pkg::SCALE_ST;
    localparam int LAST = NST - 1;
    localparam longint SAT_HI_L = (64'sd1 <<< (spi_pkg::SAT_BITS - 1)) - 64'sd1;
    localparam longint SAT_LO_L = -(64'sd1 <<< (spi_pkg::SAT_BITS - 1));
    localparam logic [VW-1:0] SAT_HI = VW'(SAT_HI_L);
    localparam logic [VW-1:0] SAT_LO = VW'(SAT_LO_L);

    logic [2:0][CW-1:0]          r_pp, r_pn;
    logic [spi_pkg::TOLW-1:0]    r_tol;
    logic [NST-1:0]              r_vld, en;
    logic [2:0][CW-1:0]          w_first, w_second;

    spi_pkg::t_info              w_dist_info, w_scl_info, w_div_info;
    logic [spi_pkg::SW-1:0]      w_mag_num;
    logic [spi_pkg::BW-1:0]      w_mag_den;
    logic [2:0][spi_pkg::XW-1:0] w_mag_d;
    logic [spi_pkg::DVW-1:0]     w_den;
    logic [2:0][spi_pkg::DVW-1:0] w_rem;
    logic [2:0][QB-1:0]          w_low, w_q;
    logic [2:0]                  w_ovf_s, w_ovf_q;

    logic [3*CW-1:0]             r_out_data, n_out_data;
    logic [3:0]                  r_out_user, n_out_user;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pp  <= '0;
            r_pn  <= {CW'(65536), CW'(0), CW'(0)};
            r_tol <= spi_pkg::TOLW'(1);
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                spi_pkg::REG_PPX: r_pp[0] <= i_cfg_data;
                spi_pkg::REG_PPY: r_pp[1] <= i_cfg_data;
                spi_pkg::REG_PPZ: r_pp[2] <= i_cfg_data;
                spi_pkg::REG_PNX: r_pn[0] <= i_cfg_data;
                spi_pkg::REG_PNY: r_pn[1] <= i_cfg_data;
                spi_pkg::REG_PNZ: r_pn[2] <= i_cfg_data;
                spi_pkg::REG_TOL: r_tol   <= i_cfg_data[spi_pkg::TOLW-1:0];
                default: ;
            endcase
        end
    end

    // a stage may load when the output drains or some stage at or after it is empty
    always_comb begin
        for (int k = 0; k < NST; k++) begin
            en[k] = i_m_axis_tready || !(&((r_vld >> k) | ~({NST{1'b1}} >> k)));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (en[0]) begin
                r_vld[0] <= i_s_axis_tvalid;
            end
            for (int k = 1; k < NST; k++) begin
                if (en[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_first[i]  = i_s_axis_tdata[i*CW +: CW];
            w_second[i] = i_s_axis_tdata[(i+3)*CW +: CW];
        end
    end

    spi_dist u_dist (
        .i_clk     (i_clk),
        .i_en      (en[S0-1:D0]),
        .i_first   (w_first),
        .i_second  (w_second),
        .i_pp      (r_pp),
        .i_pn      (r_pn),
        .i_tol     (r_tol),
        .o_info    (w_dist_info),
        .o_mag_num (w_mag_num),
        .o_mag_den (w_mag_den),
        .o_mag_d   (w_mag_d)
    );

    spi_scale u_scale (
        .i_clk     (i_clk),
        .i_en      (en[V0-1:S0]),
        .i_info    (w_dist_info),
        .i_mag_num (w_mag_num),
        .i_mag_den (w_mag_den),
        .i_mag_d   (w_mag_d),
        .o_info    (w_scl_info),
        .o_den     (w_den),
        .o_rem     (w_rem),
        .o_low     (w_low),
        .o_ovf     (w_ovf_s)
    );

    spi_div u_div (
        .i_clk  (i_clk),
        .i_en   (en[LAST-1:V0]),
        .i_info (w_scl_info),
        .i_den  (w_den),
        .i_rem  (w_rem),
        .i_low  (w_low),
        .i_ovf  (w_ovf_s),
        .o_info (w_div_info),
        .o_q    (w_q),
        .o_ovf  (w_ovf_q)
    );

    always_comb begin
        logic [VW-1:0] v;
        logic [VW-1:0] off;
        logic          sat;
        sat = 1'b0;
        n_out_data = '0;
        for (int l = 0; l < 3; l++) begin
            off = w_div_info.neg[l] ? (~VW'(w_q[l]) + VW'(1)) : VW'(w_q[l]);
            v   = VW'($signed(w_div_info.p1[l])) + off;
            if (w_div_info.deg) begin
                n_out_data[l*CW +: CW] = w_div_info.p1[l];
            end else if (w_ovf_q[l]) begin
                sat = 1'b1;
                n_out_data[l*CW +: CW] = w_div_info.neg[l] ? SAT_LO[CW-1:0] : SAT_HI[CW-1:0];
            end else if ($signed(v) > $signed(SAT_HI)) begin
                sat = 1'b1;
                n_out_data[l*CW +: CW] = SAT_HI[CW-1:0];
            end else if ($signed(v) < $signed(SAT_LO)) begin
                sat = 1'b1;
                n_out_data[l*CW +: CW] = SAT_LO[CW-1:0];
            end else begin
                n_out_data[l*CW +: CW] = v[CW-1:0];
            end
        end
        if (w_div_info.status != spi_pkg::SIDE_CROSS) begin
            n_out_data = '0;
            n_out_user = {2'b00, w_div_info.status};
        end else begin
            n_out_user = {sat, w_div_info.deg, w_div_info.status};
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[LAST]) begin
            r_out_data <= n_out_data;
            r_out_user <= n_out_user;
        end
    end

    assign o_s_axis_tready = en[0];
    assign o_m_axis_tvalid = r_vld[LAST];
    assign o_m_axis_tdata  = r_out_data;
    assign o_m_axis_tuser  = r_out_user;

`ifndef SYNTHESIS
    a_no_cross_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tuser[1:0] != spi_pkg::SIDE_CROSS
        |-> o_m_axis_tdata == '0 && o_m_axis_tuser[3:2] == 2'b00)
        else $error("non-crossing item carries a point or flags");
    a_deg_no_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> !(o_m_axis_tuser[2] && o_m_axis_tuser[3]))
        else $error("degenerate item marked saturated");
    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> o_m_axis_tuser[1:0] != 2'b11)
        else $error("bad side code");
    a_accept_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_axis_tvalid && o_s_axis_tready |=> r_vld[0])
        else $error("accepted item not in first stage");
    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready && (&r_vld) |=> !$past(o_s_axis_tready))
        else $error("input taken while pipeline full");
`endif

endmodule
`default_nettype wire
